// ----- design/grouped_inode_bitmap_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// Inode allocator assertion macros
// Shared assertion helpers for the grouped inode bitmap allocator.
// ----------------------------------------------------------------------------
`ifndef GROUPED_INODE_BITMAP_ALLOCATOR_MACROS_SVH
`define GROUPED_INODE_BITMAP_ALLOCATOR_MACROS_SVH

// Assert an implication on every clock edge outside reset.
`define GIBA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Assert an implication in the cycle after the antecedent, outside reset.
`define GIBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/giba_pkg.sv -----
// ----------------------------------------------------------------------------
// Inode allocator package
// Geometry constants, codes and types of the grouped inode bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package giba_pkg;

  localparam int unsigned MaxGroups   = 16;
  localparam int unsigned MaxPerGroup = 256;
  localparam int unsigned WordBits    = 32;
  localparam int unsigned NumWords    = (MaxGroups * MaxPerGroup + WordBits - 1) / WordBits;
  localparam int unsigned WordAw      = $clog2(NumWords);
  localparam int unsigned BitAw       = $clog2(WordBits);
  localparam int unsigned GroupAw     = $clog2(MaxGroups);
  localparam int unsigned WordsPerGrp = MaxPerGroup / WordBits;
  localparam int unsigned WpgAw       = $clog2(WordsPerGrp);
  localparam int unsigned OffW        = $clog2(MaxPerGroup) + 1;
  localparam int unsigned CntW        = 9;
  localparam int unsigned NumW        = 13;

  localparam logic [1:0] CfgIpg  = 2'd0;
  localparam logic [1:0] CfgNg   = 2'd1;
  localparam logic [1:0] CfgRsv  = 2'd2;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNone    = 2'd1;
  localparam logic [1:0] StRange   = 2'd2;
  localparam logic [1:0] StNotUsed = 2'd3;

  localparam logic ActAlloc = 1'b0;
  localparam logic ActFree  = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_FRD,
    S_FWB,
    S_APICK,
    S_ARD,
    S_ACHK,
    S_AWB,
    S_OUT
  } state_e;

endpackage

`default_nettype wire

// ----- design/grouped_inode_bitmap_allocator.sv -----
// ----------------------------------------------------------------------------
// Grouped inode bitmap allocator
// Used-bit map in a word RAM with per-group free counts and a total count.
// ----------------------------------------------------------------------------
// Channel | direction | handshake               | payload
// req     | in        | req_valid_i/req_stall_o | action, home_group, free_number
// rsp     | out       | rsp_valid_o/rsp_stall_i | allocated_number, status, total_free
// cfg     | in        | cfg_we_i                | cfg_index_i, cfg_data_i
// A free runs a five-step restoring divide by the group size, then a
// read-modify-write of one bitmap word; an out-of-range number skips both.
// An allocate steps past each group it skips and reads and checks one bitmap
// word at a time in the group it searches. After reset and after each
// configuration write to index 0, 1 or 2 a clearing pass over all 128 words
// zeroes the bitmap; no request is taken meanwhile. A result waits in the
// output register while rsp_stall_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_inode_bitmap_allocator
  import giba_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            req_valid_i,
  output logic                 req_stall_o,
  input  wire logic            action_i,
  input  wire logic [3:0]      home_group_i,
  input  wire logic [12:0]     free_number_i,
  output logic                 rsp_valid_o,
  input  wire logic            rsp_stall_i,
  output logic [12:0]          allocated_number_o,
  output logic [1:0]           status_o,
  output logic [12:0]          total_free_o,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_index_i,
  input  wire logic [8:0]      cfg_data_i
);

  state_e state_q, state_d;

  logic [8:0] ipg_q;
  logic [4:0] ng_q;
  logic [7:0] rsv_q;
  logic [8:0] ipg_eff;
  logic [4:0] ng_eff;

  logic [CntW-1:0] gcnt_q [MaxGroups];
  logic [NumW-1:0] total_q;
  logic [NumW-1:0] ftot_d;

  logic [3:0]      pref_q;
  logic [NumW-1:0] num_q;
  logic [NumW-1:0] rem_q;
  logic [GroupAw:0] quo_q;
  logic [GroupAw:0] dstep_q;
  logic [GroupAw:0] grp_q;
  logic            pref_try_q;
  logic [WpgAw:0]  widx_q;
  logic [WordAw:0] clr_q;

  logic [12:0] anum_q;
  logic [1:0]  stat_q;
  logic        ovalid_q;

  logic            ram_we;
  logic [WordAw-1:0] ram_wa, ram_ra;
  logic [WordBits-1:0] ram_wd, ram_rd;

  logic [GroupAw-1:0] g_lo;
  logic [WordAw-1:0]  cur_word;
  logic [WordBits-1:0] avail;
  logic [BitAw-1:0]    fbit;
  logic                ffound;
  logic [OffW-1:0]     base_off;
  logic [OffW-1:0]     aoff;
  logic [NumW-1:0]     limit;
  logic [NumW-1:0]     shifted;
  logic [NumW-1:0]     lin;
  logic                pref_ok;
  logic                words_done;
  logic [BitAw-1:0]    fr_bit;
  logic [WordAw-1:0]   fr_word;

  always_comb begin
    ipg_eff = ipg_q;
    if (ipg_q < 9'd8) ipg_eff = 9'd8;
    if (ipg_q > 9'(MaxPerGroup)) ipg_eff = 9'(MaxPerGroup);
    ng_eff = ng_q;
    if (ng_q == 5'd0) ng_eff = 5'd1;
    if (ng_q > 5'(MaxGroups)) ng_eff = 5'(MaxGroups);
  end

  assign limit    = NumW'(ipg_eff) * NumW'(ng_eff);
  assign g_lo     = grp_q[GroupAw-1:0];
  assign cur_word = {g_lo, widx_q[WpgAw-1:0]};
  assign base_off = {1'b0, widx_q[WpgAw-1:0], BitAw'(0)};
  assign pref_ok  = (pref_q != 4'd0) && ({1'b0, pref_q} < ng_eff)
                    && (gcnt_q[pref_q[GroupAw-1:0]] != '0);
  assign words_done = ({widx_q, BitAw'(0)} >= (WpgAw + BitAw + 1)'(ipg_eff));

  always_comb begin
    for (int b = 0; b < WordBits; b++) begin
      logic [OffW-1:0] o;
      o = base_off + OffW'(b);
      avail[b] = !ram_rd[b] && (o < OffW'(ipg_eff))
                 && !((grp_q == '0) && (o < OffW'(rsv_q)));
    end
  end

  always_comb begin
    fbit = '0;
    ffound = 1'b0;
    for (int b = WordBits - 1; b >= 0; b--) begin
      if (avail[b]) begin
        fbit = BitAw'(b);
        ffound = 1'b1;
      end
    end
  end

  assign aoff = base_off + OffW'(fbit);
  assign shifted = NumW'(ipg_eff) << dstep_q;
  assign lin  = {1'b0, quo_q[GroupAw-1:0], rem_q[OffW-2:0]};
  assign fr_word = lin[BitAw +: WordAw];
  assign fr_bit  = lin[BitAw-1:0];

  giba_ram #(.Width(WordBits), .Depth(NumWords)) u_bits (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wa),
    .wdata_i (ram_wd),
    .raddr_i (ram_ra),
    .rdata_o (ram_rd)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == (WordAw + 1)'(NumWords - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (req_valid_i) begin
          if (action_i == ActFree) state_d = S_DIV;
          else state_d = S_APICK;
        end
      end
      S_DIV: begin
        if (num_q == '0 || num_q > limit) state_d = S_OUT;
        else if (dstep_q == '0) state_d = S_FRD;
      end
      S_FRD:   state_d = S_FWB;
      S_FWB:   state_d = S_OUT;
      S_APICK: state_d = S_ARD;
      S_ARD: begin
        if (grp_q >= (GroupAw + 1)'(ng_eff)) state_d = S_OUT;
        else if (gcnt_q[g_lo] == '0 || words_done) state_d = S_ARD;
        else state_d = S_ACHK;
      end
      S_ACHK: state_d = ffound ? S_AWB : S_ARD;
      S_AWB:  state_d = S_OUT;
      S_OUT:  if (!rsp_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (cfg_we_i && cfg_index_i <= CfgRsv) state_d = S_CLEAR;
  end

  always_comb begin
    ram_we = 1'b0;
    ram_wa = cur_word;
    ram_wd = ram_rd;
    ram_ra = cur_word;
    unique case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_wa = clr_q[WordAw-1:0];
        ram_wd = '0;
      end
      S_FRD: ram_ra = fr_word;
      S_FWB: begin
        ram_wa = fr_word;
        ram_wd = ram_rd & ~(WordBits'(1) << fr_bit);
        ram_we = ram_rd[fr_bit];
      end
      S_AWB: begin
        ram_we = 1'b1;
        ram_wd = ram_rd | (WordBits'(1) << fbit);
      end
      default: ;
    endcase
  end

  assign req_stall_o = (state_q != S_IDLE);
  assign rsp_valid_o = ovalid_q;
  assign allocated_number_o = anum_q;
  assign status_o = stat_q;
  assign total_free_o = total_q;
  assign ftot_d = NumW'(ipg_eff) * NumW'(ng_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ipg_q <= 9'd256;
      ng_q <= 5'd16;
      rsv_q <= 8'd11;
      clr_q <= '0;
      ovalid_q <= 1'b0;
      total_q <= NumW'(MaxGroups * MaxPerGroup);
      for (int g = 0; g < MaxGroups; g++) gcnt_q[g] <= CntW'(MaxPerGroup);
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_CLEAR: begin
          total_q <= ftot_d;
          for (int g = 0; g < MaxGroups; g++)
            gcnt_q[g] <= (g < ng_eff) ? ipg_eff : '0;
        end
        S_IDLE: begin
          if (req_valid_i) begin
            pref_q <= home_group_i;
            num_q <= free_number_i;
            rem_q <= free_number_i - NumW'(1);
            quo_q <= '0;
            dstep_q <= (GroupAw + 1)'(GroupAw);
            widx_q <= '0;
            anum_q <= '0;
            stat_q <= StOk;
          end
        end
        S_DIV: begin
          if (num_q == '0 || num_q > limit) begin
            stat_q <= StRange;
            ovalid_q <= 1'b1;
          end else begin
            if (rem_q >= shifted) begin
              rem_q <= rem_q - shifted;
              quo_q <= quo_q | ((GroupAw + 1)'(1) << dstep_q);
            end
            dstep_q <= dstep_q - 1'b1;
          end
        end
        S_FWB: begin
          ovalid_q <= 1'b1;
          if (!ram_rd[fr_bit]) begin
            stat_q <= StNotUsed;
          end else begin
            gcnt_q[quo_q[GroupAw-1:0]] <= gcnt_q[quo_q[GroupAw-1:0]] + 1'b1;
            total_q <= total_q + 1'b1;
          end
        end
        S_APICK: begin
          pref_try_q <= pref_ok;
          grp_q <= pref_ok ? (GroupAw + 1)'(pref_q) : '0;
        end
        S_ARD: begin
          if (grp_q >= (GroupAw + 1)'(ng_eff)) begin
            stat_q <= StNone;
            ovalid_q <= 1'b1;
          end else if (gcnt_q[g_lo] == '0 || words_done) begin
            widx_q <= '0;
            grp_q <= pref_try_q ? '0 : grp_q + 1'b1;
            pref_try_q <= 1'b0;
          end
        end
        S_ACHK: if (!ffound) widx_q <= widx_q + 1'b1;
        S_AWB: begin
          ovalid_q <= 1'b1;
          gcnt_q[g_lo] <= gcnt_q[g_lo] - 1'b1;
          if (total_q != '0) total_q <= total_q - 1'b1;
          anum_q <= NumW'(g_lo) * NumW'(ipg_eff) + NumW'(aoff) + NumW'(1);
        end
        S_OUT: if (!rsp_stall_i) ovalid_q <= 1'b0;
        default: ;
      endcase
      if (cfg_we_i && cfg_index_i <= CfgRsv) begin
        clr_q <= '0;
      end else if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgIpg: ipg_q <= cfg_data_i;
          CfgNg:  ng_q <= cfg_data_i[4:0];
          CfgRsv: rsv_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  `include "grouped_inode_bitmap_allocator_macros.svh"

  `GIBA_ASSERT_IMP(a_out_valid, state_q == S_OUT, ovalid_q)
  `GIBA_ASSERT_IMP(a_stall_busy, ovalid_q, req_stall_o)
  `GIBA_ASSERT_NEXT(a_alloc_num, state_q == S_AWB, anum_q != '0 && stat_q == StOk)
  `GIBA_ASSERT_IMP(a_clear_we, state_q == S_CLEAR, ram_we && ram_wd == '0)

endmodule

`default_nettype wire

// ----- design/giba_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module giba_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire
